### rtl/core/type_hierarchy_ancestor_check_core_assert.svh
// Assertion helpers shared by the core's modules.
`ifndef TYPE_HIERARCHY_ANCESTOR_CHECK_CORE_ASSERT_SVH
`define TYPE_HIERARCHY_ANCESTOR_CHECK_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define THAC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define THAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/thac_pkg.sv
`default_nettype none
package thac_pkg;

  // Action codes of an input item
  localparam logic ACT_REGISTER = 1'b0;
  localparam logic ACT_QUERY    = 1'b1;

  // Entries 0 to 2 exist after reset, all with parent 0
  localparam int RESET_COUNT = 3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } thac_status_t;

  typedef enum logic [1:0] {
    WK_IDLE,
    WK_STEP,
    WK_HOLD
  } thac_walk_state_t;

  // Request from the front end to the chain walker
  typedef struct packed {
    logic       start;
    logic       ack;
    logic [7:0] node;
    logic [7:0] anc;
  } thac_walk_req_t;

  // Status of the chain walker
  typedef struct packed {
    logic busy;
    logic done;
    logic hit;
  } thac_walk_rsp_t;

endpackage
`default_nettype wire

### rtl/core/thac_parent_mem.sv
`default_nettype none
module thac_parent_mem #(
  parameter int MAX_TYPES = 256
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(MAX_TYPES)-1:0] wr_addr,
  input  wire logic [7:0]                   wr_data,
  input  wire logic                         rd_en,
  input  wire logic [7:0]                   rd_addr,
  output logic      [7:0]                   rd_data
);

  localparam int AW = $clog2(MAX_TYPES);

  logic [7:0] mem [MAX_TYPES];
  logic [7:0] rd_q_r;
  logic       rd_low_r;

  // Store a new parent entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one entry; the entries present at reset are decoded, never stored
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r   <= mem[AW'(rd_addr)];
      rd_low_r <= (rd_addr < 8'(thac_pkg::RESET_COUNT));
    end
  end

  assign rd_data = rd_low_r ? 8'd0 : rd_q_r;

endmodule
`default_nettype wire

### rtl/core/thac_walker.sv
`default_nettype none
`include "type_hierarchy_ancestor_check_core_assert.svh"
module thac_walker (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire thac_pkg::thac_walk_req_t req,
  output thac_pkg::thac_walk_rsp_t      rsp,
  output logic                          rd_en,
  output logic [7:0]                    rd_addr,
  input  wire logic [7:0]               rd_data
);

  thac_pkg::thac_walk_state_t state_r, state_nxt;
  logic [7:0] anc_r, anc_nxt;
  logic       hit_r, hit_nxt;
  logic       found;
  logic       stop;

  // Parents always sit below their child, so a parent below the ancestor ends the walk
  assign found = (rd_data == anc_r);
  assign stop  = (rd_data < anc_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      thac_pkg::WK_IDLE: begin
        if (req.start) state_nxt = thac_pkg::WK_STEP;
      end
      thac_pkg::WK_STEP: begin
        if (found || stop) state_nxt = thac_pkg::WK_HOLD;
      end
      thac_pkg::WK_HOLD: begin
        if (req.ack) state_nxt = thac_pkg::WK_IDLE;
      end
      default: state_nxt = thac_pkg::WK_IDLE;
    endcase
  end

  // Outputs and data path
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rd_data;
    anc_nxt = anc_r;
    hit_nxt = hit_r;
    rsp     = '0;
    unique case (state_r)
      thac_pkg::WK_IDLE: begin
        rd_addr = req.node;
        if (req.start) begin
          rd_en   = 1'b1;
          anc_nxt = req.anc;
        end
      end
      thac_pkg::WK_STEP: begin
        rsp.busy = 1'b1;
        if (found || stop) begin
          hit_nxt = found;
        end else begin
          rd_en = 1'b1;
        end
      end
      thac_pkg::WK_HOLD: begin
        rsp.busy = 1'b1;
        rsp.done = 1'b1;
      end
      default: begin
        rsp.busy = 1'b1;
      end
    endcase
    rsp.hit = hit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= thac_pkg::WK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    anc_r <= anc_nxt;
    hit_r <= hit_nxt;
  end

  `THAC_ASSERT_IMPL(a_start_idle, clk, rst_n, req.start, state_r == thac_pkg::WK_IDLE, "walk started while busy")
  `THAC_ASSERT_IMPL(a_anc_nonzero, clk, rst_n, state_r == thac_pkg::WK_STEP, anc_r != 8'd0, "walk toward the root")
  `THAC_ASSERT_NEXT(a_step_reads, clk, rst_n, state_r == thac_pkg::WK_STEP && !found && !stop, state_r == thac_pkg::WK_STEP, "walk left early")

endmodule
`default_nettype wire

### rtl/core/type_hierarchy_ancestor_check_core.sv
// Type hierarchy kept as a table of parent indices in one synchronous memory,
// entry 0 the root. A registration transfer (action 0) appends an entry under
// the given parent and returns its index; a query transfer (action 1) reports
// whether node equals or descends from ancestor. Registrations, bad indices and
// queries settled by index comparison load the output register directly. A
// query that walks the chain reads one parent entry per step through the
// single memory read port until the ancestor is found or passed. A walk reads
// only entries 2 and up, so it makes at most 254 parent reads at 256 entries
// (MAX_TYPES - 2 for smaller tables; the 8-bit fields name no entry past 255).
// Entries 0 to 2 are decoded at the read port, so no clearing pass follows
// reset. One item is in work at a time; a finished result waits in the output
// register, and the next input transfer is taken once that register is empty
// or in the cycle of its output transfer.
`default_nettype none
`include "type_hierarchy_ancestor_check_core_assert.svh"
module type_hierarchy_ancestor_check_core #(
  parameter int MAX_TYPES = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_action,
  input  wire logic [7:0] in_node,
  input  wire logic [7:0] in_ancestor,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_status,
  output logic [7:0]      out_new_index,
  output logic            out_is_descendant
);

  localparam int AW = $clog2(MAX_TYPES);
  localparam int CW = $clog2(MAX_TYPES + 1);

  logic [CW-1:0] entry_count_r, entry_count_nxt;
  logic          out_valid_r, out_valid_nxt;
  thac_pkg::thac_status_t out_status_r, out_status_nxt;
  logic [7:0]    out_new_index_r, out_new_index_nxt;
  logic          out_desc_r, out_desc_nxt;

  thac_pkg::thac_walk_req_t wk_req;
  thac_pkg::thac_walk_rsp_t wk_rsp;
  logic       rd_en;
  logic [7:0] rd_addr;
  logic [7:0] rd_data;

  logic in_fire;
  logic out_free;
  logic node_ok;
  logic anc_ok;
  logic full;
  logic reg_ok;
  logic need_walk;
  logic load_out;

  // Decode the incoming item
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = !wk_rsp.busy && out_free;
  assign in_fire   = in_valid && in_ready;
  assign node_ok   = 32'(in_node) < 32'(entry_count_r);
  assign anc_ok    = 32'(in_ancestor) < 32'(entry_count_r);
  assign full      = (entry_count_r == CW'(MAX_TYPES));
  assign reg_ok    = node_ok && !full;
  assign need_walk = (in_action == thac_pkg::ACT_QUERY) && node_ok && anc_ok
                     && (in_node > in_ancestor) && (in_ancestor != 8'd0);

  // Drive the walker
  always_comb begin
    wk_req       = '0;
    wk_req.start = in_fire && need_walk;
    wk_req.ack   = wk_rsp.done && out_free;
    wk_req.node  = in_node;
    wk_req.anc   = in_ancestor;
  end

  // Settle the result and the entry count
  always_comb begin
    entry_count_nxt   = entry_count_r;
    out_status_nxt    = out_status_r;
    out_new_index_nxt = out_new_index_r;
    out_desc_nxt      = out_desc_r;
    load_out          = 1'b0;
    if (in_fire && !need_walk) begin
      load_out          = 1'b1;
      out_status_nxt    = thac_pkg::ST_OK;
      out_new_index_nxt = 8'd0;
      out_desc_nxt      = 1'b0;
      if (in_action == thac_pkg::ACT_REGISTER) begin
        if (!node_ok) begin
          out_status_nxt = thac_pkg::ST_BAD_INDEX;
        end else if (full) begin
          out_status_nxt = thac_pkg::ST_FULL;
        end else begin
          out_new_index_nxt = 8'(entry_count_r);
          entry_count_nxt   = entry_count_r + CW'(1);
        end
      end else begin
        if (!node_ok || !anc_ok) begin
          out_status_nxt = thac_pkg::ST_BAD_INDEX;
        end else begin
          out_desc_nxt = (in_node >= in_ancestor);
        end
      end
    end else if (wk_req.ack) begin
      load_out          = 1'b1;
      out_status_nxt    = thac_pkg::ST_OK;
      out_new_index_nxt = 8'd0;
      out_desc_nxt      = wk_rsp.hit;
    end
  end

  // Hold the result until the output transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= CW'(thac_pkg::RESET_COUNT);
      out_valid_r   <= 1'b0;
    end else begin
      entry_count_r <= entry_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r    <= out_status_nxt;
    out_new_index_r <= out_new_index_nxt;
    out_desc_r      <= out_desc_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_new_index     = out_new_index_r;
  assign out_is_descendant = out_desc_r;

  thac_parent_mem #(
    .MAX_TYPES(MAX_TYPES)
  ) u_mem (
    .clk     (clk),
    .wr_en   (in_fire && (in_action == thac_pkg::ACT_REGISTER) && reg_ok),
    .wr_addr (entry_count_r[AW-1:0]),
    .wr_data (in_node),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  thac_walker u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (wk_req),
    .rsp     (wk_rsp),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  `THAC_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1,
    entry_count_r <= CW'(MAX_TYPES), "entry count past table size")
  `THAC_ASSERT_NEXT(a_count_inc, clk, rst_n,
    in_fire && in_action == thac_pkg::ACT_REGISTER && reg_ok,
    entry_count_r == $past(entry_count_r) + CW'(1), "registration not counted")
  `THAC_ASSERT_IMPL(a_full_status, clk, rst_n,
    out_valid_r && out_status_r == thac_pkg::ST_FULL, full, "full reported below capacity")
  `THAC_ASSERT_IMPL(a_desc_ok, clk, rst_n, out_valid_r && out_desc_r,
    out_status_r == thac_pkg::ST_OK, "descendant flagged on error")

endmodule
`default_nettype wire
